FILE: src/mi3_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_pkg: shared types and constants of the 3x3 matrix inverse
// Field widths, internal word sizes, cofactor index tables and the payload
// structs that travel between the pipeline sections.
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int NLANE      = 9;

    // internal word sizes
    localparam int PW  = 2 * DATA_WIDTH;              // element product
    localparam int AW  = 2 * DATA_WIDTH + 1;          // cofactor, signed
    localparam int MW  = 2 * DATA_WIDTH + 1;          // det partial product
    localparam int DW  = 3 * DATA_WIDTH + 3;          // determinant, signed
    localparam int DMW = 3 * DATA_WIDTH;              // determinant magnitude
    localparam int NW  = 2 * DATA_WIDTH + 2 * FRAC_BITS; // dividend magnitude
    localparam int RW  = 4 * DATA_WIDTH;              // partial remainder

    // cofactor i = a[X]*a[Y] - a[U]*a[V], row-major element numbering
    localparam int CF_X [NLANE] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int CF_Y [NLANE] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int CF_U [NLANE] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
    localparam int CF_V [NLANE] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] a00;
        logic signed [DATA_WIDTH-1:0] a01;
        logic signed [DATA_WIDTH-1:0] a02;
        logic signed [DATA_WIDTH-1:0] a10;
        logic signed [DATA_WIDTH-1:0] a11;
        logic signed [DATA_WIDTH-1:0] a12;
        logic signed [DATA_WIDTH-1:0] a20;
        logic signed [DATA_WIDTH-1:0] a21;
        logic signed [DATA_WIDTH-1:0] a22;
    } in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] r00;
        logic signed [DATA_WIDTH-1:0] r01;
        logic signed [DATA_WIDTH-1:0] r02;
        logic signed [DATA_WIDTH-1:0] r10;
        logic signed [DATA_WIDTH-1:0] r11;
        logic signed [DATA_WIDTH-1:0] r12;
        logic signed [DATA_WIDTH-1:0] r20;
        logic signed [DATA_WIDTH-1:0] r21;
        logic signed [DATA_WIDTH-1:0] r22;
        logic signed [DATA_WIDTH-1:0] det_value;
        logic                         singular;
    } out_t;

    // one division lane: partial remainder and quotient bits so far
    typedef struct packed {
        logic [RW-1:0]         rem;
        logic [DATA_WIDTH-1:0] quo;
        logic                  ovf;
        logic                  neg;
    } lane_t;

    typedef struct packed {
        lane_t [NLANE-1:0]     lane;
        logic [DMW-1:0]        det_mag;
        logic [DATA_WIDTH-1:0] det_out;
        logic                  singular;
        in_t                   mat;
    } div_item_t;

endpackage
`default_nettype wire

FILE: src/mi3_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_front: cofactors, determinant and divider setup
// Five register stages: element products, cofactors, split determinant
// products, determinant sum, then magnitudes, overflow check and det output.
// ----------------------------------------------------------------------------
module mi3_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mi3_pkg::in_t      in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output mi3_pkg::div_item_t     out_data
);

    localparam int W   = mi3_pkg::DATA_WIDTH;
    localparam int F   = mi3_pkg::FRAC_BITS;
    localparam int PW  = mi3_pkg::PW;
    localparam int AW  = mi3_pkg::AW;
    localparam int MW  = mi3_pkg::MW;
    localparam int DW  = mi3_pkg::DW;
    localparam int DMW = mi3_pkg::DMW;
    localparam int NW  = mi3_pkg::NW;
    localparam int RW  = mi3_pkg::RW;
    localparam int NL  = mi3_pkg::NLANE;

    logic signed [W-1:0] a [NL];

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    mi3_pkg::in_t mat1_reg, mat2_reg, mat3_reg, mat4_reg;
    logic signed [PW-1:0] pp_reg [NL];
    logic signed [PW-1:0] pq_reg [NL];
    logic signed [AW-1:0] adj2_reg [NL];
    logic signed [AW-1:0] adj3_reg [NL];
    logic signed [AW-1:0] adj4_reg [NL];
    logic signed [MW-1:0] plo_reg [3];
    logic signed [MW-1:0] phi_reg [3];
    logic signed [DW-1:0] det4_reg;
    mi3_pkg::div_item_t   item_reg;
    mi3_pkg::div_item_t   item_next;

    assign a[0] = in_data.a00;
    assign a[1] = in_data.a01;
    assign a[2] = in_data.a02;
    assign a[3] = in_data.a10;
    assign a[4] = in_data.a11;
    assign a[5] = in_data.a12;
    assign a[6] = in_data.a20;
    assign a[7] = in_data.a21;
    assign a[8] = in_data.a22;

    // a stage moves when it is empty or its successor moves
    assign en5      = !v5_reg || out_ready;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // stage 1: the eighteen element products
    always_ff @(posedge aclk) begin
        if (en1) begin
            mat1_reg <= in_data;
            for (int i = 0; i < NL; i++) begin
                pp_reg[i] <= PW'(a[mi3_pkg::CF_X[i]]) * PW'(a[mi3_pkg::CF_Y[i]]);
                pq_reg[i] <= PW'(a[mi3_pkg::CF_U[i]]) * PW'(a[mi3_pkg::CF_V[i]]);
            end
        end
    end

    // stage 2: cofactors
    always_ff @(posedge aclk) begin
        if (en2) begin
            mat2_reg <= mat1_reg;
            for (int i = 0; i < NL; i++) begin
                adj2_reg[i] <= AW'(pp_reg[i]) - AW'(pq_reg[i]);
            end
        end
    end

    // stage 3: row 0 times cofactors, cofactor split in low and high halves
    logic signed [W-1:0] row0 [3];
    assign row0[0] = mat2_reg.a00;
    assign row0[1] = mat2_reg.a01;
    assign row0[2] = mat2_reg.a02;

    always_ff @(posedge aclk) begin
        if (en3) begin
            mat3_reg <= mat2_reg;
            adj3_reg <= adj2_reg;
            for (int t = 0; t < 3; t++) begin
                plo_reg[t] <= MW'(row0[t]) * MW'($signed({1'b0, adj2_reg[3*t][W-1:0]}));
                phi_reg[t] <= MW'(row0[t]) * MW'($signed(adj2_reg[3*t][AW-1:W]));
            end
        end
    end

    // stage 4: determinant at full precision
    always_ff @(posedge aclk) begin
        if (en4) begin
            mat4_reg <= mat3_reg;
            adj4_reg <= adj3_reg;
            det4_reg <= (DW'(phi_reg[0]) <<< W) + DW'(plo_reg[0])
                      + (DW'(phi_reg[1]) <<< W) + DW'(plo_reg[1])
                      + (DW'(phi_reg[2]) <<< W) + DW'(plo_reg[2]);
        end
    end

    // stage 5: magnitudes, quotient overflow test and saturated det
    always_comb begin
        logic           det_neg;
        logic [DW-1:0]  det_abs;
        logic [DMW-1:0] det_mag;
        logic [DMW-1:0] det_q;
        logic [RW-1:0]  det_hi;
        logic [AW-1:0]  adj_abs;
        logic [NW-1:0]  num;
        logic [RW-1:0]  num_ext;
        logic [W-1:0]   lim;

        lim     = {1'b1, {(W-1){1'b0}}};
        det_neg = det4_reg[DW-1];
        det_abs = det_neg ? DW'(-det4_reg) : DW'(det4_reg);
        det_mag = det_abs[DMW-1:0];
        det_hi  = {det_mag, {W{1'b0}}};
        det_q   = det_mag >> (2 * F);

        item_next.det_mag  = det_mag;
        item_next.singular = (det_mag == '0);
        item_next.mat      = mat4_reg;
        if (!det_neg) begin
            item_next.det_out = (det_q > DMW'(lim - 1'b1)) ? (lim - 1'b1) : det_q[W-1:0];
        end else begin
            item_next.det_out = (det_q > DMW'(lim)) ? lim : W'(-det_q[W-1:0]);
        end

        for (int i = 0; i < NL; i++) begin
            adj_abs = adj4_reg[i][AW-1] ? AW'(-adj4_reg[i]) : AW'(adj4_reg[i]);
            num     = {adj_abs[PW-1:0], {(2*F){1'b0}}};
            num_ext = RW'(num);
            item_next.lane[i].rem = num_ext;
            item_next.lane[i].quo = '0;
            item_next.lane[i].ovf = (num_ext >= det_hi);
            item_next.lane[i].neg = adj4_reg[i][AW-1] ^ det_neg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en5) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = item_reg;

endmodule
`default_nettype wire

FILE: src/mi3_div_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_div_step: one restoring division step for all nine lanes
// Settles quotient bit SHIFT of every lane against the shared determinant.
// ----------------------------------------------------------------------------
module mi3_div_step #(
    parameter int SHIFT = 0
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire mi3_pkg::div_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output mi3_pkg::div_item_t       out_item
);

    localparam int RW  = mi3_pkg::RW;
    localparam int DMW = mi3_pkg::DMW;

    logic               valid_reg;
    mi3_pkg::div_item_t item_reg;
    mi3_pkg::div_item_t item_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        logic [RW-1:0] trial;
        trial     = {{(RW-DMW){1'b0}}, in_item.det_mag} << SHIFT;
        item_next = in_item;
        for (int i = 0; i < mi3_pkg::NLANE; i++) begin
            if (in_item.lane[i].rem >= trial) begin
                item_next.lane[i].rem        = in_item.lane[i].rem - trial;
                item_next.lane[i].quo[SHIFT] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
`default_nettype wire

FILE: src/matrix3_inverse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// matrix3_inverse: pipelined 3x3 matrix inverse, adjugate over determinant
// Signed Q16.16 elements in, saturated Q16.16 inverse and determinant out;
// a singular matrix is passed through with the singular flag set.
// ----------------------------------------------------------------------------
//  channel   ports                          payload
//  input     s_valid, s_ready, s_data       mi3_pkg::in_t  (a00..a22)
//  result    m_valid, m_ready, m_data       mi3_pkg::out_t (r00..r22, det, flag)
//
//  one matrix per cycle sustained while m_ready stays high; five setup stages,
//  one division step per quotient bit, then the output register.
//  every stage holds its own valid bit and moves when empty or drained, so
//  a stall on m_ready backs up stage by stage and bubbles are squeezed out.
//  reset clears the valid bits only.
// ----------------------------------------------------------------------------
module matrix3_inverse (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire mi3_pkg::in_t   s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output mi3_pkg::out_t       m_data
);

    localparam int W  = mi3_pkg::DATA_WIDTH;
    localparam int NL = mi3_pkg::NLANE;

    logic               chain_valid [W+1];
    logic               chain_ready [W+1];
    mi3_pkg::div_item_t chain_item  [W+1];

    logic          m_valid_reg;
    mi3_pkg::out_t m_data_reg;
    mi3_pkg::out_t m_data_next;
    logic          out_en;

    mi3_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_item[0])
    );

    // quotient bits from the top down
    for (genvar j = 0; j < W; j++) begin : g_step
        mi3_div_step #(
            .SHIFT (W - 1 - j)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[j]),
            .in_ready  (chain_ready[j]),
            .in_item   (chain_item[j]),
            .out_valid (chain_valid[j+1]),
            .out_ready (chain_ready[j+1]),
            .out_item  (chain_item[j+1])
        );
    end

    assign out_en         = !m_valid_reg || m_ready;
    assign chain_ready[W] = out_en;

    // sign, saturation and singular pass-through
    always_comb begin
        logic [W-1:0] lim;
        logic [W-1:0] res [NL];
        logic [W-1:0] q;
        mi3_pkg::in_t mt;

        lim = {1'b1, {(W-1){1'b0}}};
        mt  = chain_item[W].mat;
        for (int i = 0; i < NL; i++) begin
            q = chain_item[W].lane[i].quo;
            if (!chain_item[W].lane[i].neg) begin
                res[i] = (chain_item[W].lane[i].ovf || q[W-1]) ? (lim - 1'b1) : q;
            end else begin
                res[i] = (chain_item[W].lane[i].ovf || q > lim) ? lim : W'(-q);
            end
        end

        if (chain_item[W].singular) begin
            m_data_next.r00       = mt.a00;
            m_data_next.r01       = mt.a01;
            m_data_next.r02       = mt.a02;
            m_data_next.r10       = mt.a10;
            m_data_next.r11       = mt.a11;
            m_data_next.r12       = mt.a12;
            m_data_next.r20       = mt.a20;
            m_data_next.r21       = mt.a21;
            m_data_next.r22       = mt.a22;
            m_data_next.det_value = '0;
            m_data_next.singular  = 1'b1;
        end else begin
            m_data_next.r00       = res[0];
            m_data_next.r01       = res[1];
            m_data_next.r02       = res[2];
            m_data_next.r10       = res[3];
            m_data_next.r11       = res[4];
            m_data_next.r12       = res[5];
            m_data_next.r20       = res[6];
            m_data_next.r21       = res[7];
            m_data_next.r22       = res[8];
            m_data_next.det_value = chain_item[W].det_out;
            m_data_next.singular  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_en) begin
            m_valid_reg <= chain_valid[W];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire
